// ----- sv/linear_probe_hash_table_assert.svh -----
// assertion macros for the linear probe hash table
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// implication checked every clock, quiet during reset
`define LPHT_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define LPHT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/lpht_pkg.sv -----
// shared types and constants for the linear probe hash table
package lpht_pkg;
   localparam int DEPTH_DEF       = 256;
   localparam int PROBE_LIMIT_DEF = 20;
   localparam int KEY_BITS_DEF    = 32;
   localparam int HASH_BITS_DEF   = 32;
   localparam int DATA_BITS_DEF   = 32;
   localparam int KEY_W    = 32;
   localparam int HASH_W   = 32;
   localparam int DATA_W   = 32;
   localparam int LIMIT_W  = 9;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 3;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [2:0] ST_ADDED    = 3'd0;
   localparam logic [2:0] ST_DUP      = 3'd1;
   localparam logic [2:0] ST_NOSPACE  = 3'd2;
   localparam logic [2:0] ST_FOUND    = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request word, start modulo
      logic mod_step;   // one restoring-division step
      logic probe_rd;   // issue memory read at probe index
      logic advance;    // step probe index
      logic do_write;   // write slot and set valid
      logic do_clear;   // clear valid of probe slot
      logic set_resp;   // load response word
      logic [2:0] status;
      logic use_data;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic mod_done;
      logic slot_valid;
      logic slot_match;
      logic wrap_home;   // next index equals home
      logic limit_hit;   // probe count reached limit
      logic [1:0] op;
   } sts_type;
endpackage

// ----- sv/lpht_datapath.sv -----
// datapath: modulo unit, probe index, slot stores, response register
module lpht_datapath #(
   parameter int DEPTH       = 256,
   parameter int PROBE_LIMIT = 20,
   parameter int KEY_BITS    = 32,
   parameter int HASH_BITS   = 32,
   parameter int DATA_BITS   = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lpht_pkg::cmd_type           cmd,
   output lpht_pkg::sts_type           sts,
   input  logic [1:0]                  req_operation,
   input  logic [lpht_pkg::KEY_W-1:0]  req_key,
   input  logic [lpht_pkg::HASH_W-1:0] req_hash_code,
   input  logic [lpht_pkg::DATA_W-1:0] req_write_data,
   input  logic [lpht_pkg::LIMIT_W-1:0] limit,
   output logic [lpht_pkg::STATUS_W-1:0] rsp_status,
   output logic [lpht_pkg::DATA_W-1:0] rsp_read_data,
   output logic [lpht_pkg::COUNT_W-1:0] rsp_entry_count
);
   import lpht_pkg::*;
   localparam int IW = $clog2(DEPTH);
   localparam int NW = IW + 1;
   localparam int PW = $clog2(PROBE_LIMIT + 1);
   localparam int MW = (HASH_BITS > 32) ? 32 : HASH_BITS;

   logic [1:0]           op_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [MW-1:0]        hash_ff;
   logic [DATA_BITS-1:0] data_ff;
   logic [NW-1:0]        lim_ff;
   logic [MW-1:0]        quo_ff;
   logic [NW:0]          rem_ff;
   logic [5:0]           bit_ff;
   logic [IW-1:0]        idx_ff, home_ff;
   logic [PW-1:0]        steps_ff;
   logic [DEPTH-1:0]     valid_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 vld_rd_ff;

   logic [KEY_BITS-1:0]  mem_key  [DEPTH];
   logic [MW-1:0]        mem_hash [DEPTH];
   logic [DATA_BITS-1:0] mem_data [DEPTH];
   logic [KEY_BITS-1:0]  rd_key_ff;
   logic [MW-1:0]        rd_hash_ff;
   logic [DATA_BITS-1:0] rd_data_ff;

   logic [NW-1:0] lim_eff;
   logic [NW:0]   rem_sh;
   logic [IW-1:0] idx_nx;
   logic [NW-1:0] idx_nx_wide;

   always_comb begin
      if (limit == '0) begin
         lim_eff = NW'(1);
      end else if (32'(limit) > DEPTH) begin
         lim_eff = NW'(DEPTH);
      end else begin
         lim_eff = NW'(limit);
      end
      rem_sh = {rem_ff[NW-1:0], quo_ff[MW-1]};
      idx_nx_wide = NW'(idx_ff) + NW'(1);
      idx_nx = (idx_nx_wide == lim_ff) ? '0 : idx_nx_wide[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.do_write) begin
            valid_ff[idx_ff] <= 1'b1;
            if (32'(count_ff) < DEPTH) count_ff <= count_ff + COUNT_W'(1);
         end
         if (cmd.do_clear) begin
            valid_ff[idx_ff] <= 1'b0;
            if (count_ff != '0) count_ff <= count_ff - COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         key_ff  <= KEY_BITS'(req_key);
         hash_ff <= MW'(req_hash_code);
         data_ff <= DATA_BITS'(req_write_data);
         lim_ff  <= lim_eff;
         quo_ff  <= MW'(req_hash_code);
         rem_ff  <= '0;
         bit_ff  <= '0;
      end else if (cmd.mod_step) begin
         // one restoring step per cycle
         if (rem_sh >= {1'b0, lim_ff}) begin
            rem_ff <= rem_sh - {1'b0, lim_ff};
         end else begin
            rem_ff <= rem_sh;
         end
         quo_ff <= {quo_ff[MW-2:0], 1'b0};
         bit_ff <= bit_ff + 6'd1;
         if (32'(bit_ff) == MW - 1) begin
            idx_ff   <= (rem_sh >= {1'b0, lim_ff}) ? IW'(rem_sh - {1'b0, lim_ff}) : IW'(rem_sh);
            home_ff  <= (rem_sh >= {1'b0, lim_ff}) ? IW'(rem_sh - {1'b0, lim_ff}) : IW'(rem_sh);
            steps_ff <= '0;
         end
      end else if (cmd.advance) begin
         idx_ff   <= idx_nx;
         steps_ff <= steps_ff + PW'(1);
      end
      if (cmd.probe_rd) begin
         rd_key_ff  <= mem_key[idx_ff];
         rd_hash_ff <= mem_hash[idx_ff];
         rd_data_ff <= mem_data[idx_ff];
         vld_rd_ff  <= valid_ff[idx_ff];
      end
      if (cmd.do_write) begin
         mem_key[idx_ff]  <= key_ff;
         mem_hash[idx_ff] <= hash_ff;
         mem_data[idx_ff] <= data_ff;
      end
      if (cmd.set_resp) begin
         rsp_status    <= cmd.status;
         rsp_read_data <= cmd.use_data ? DATA_W'(rd_data_ff) : '0;
      end
   end

   // count after write/clear lands next cycle; response count taken from next value
   always_ff @(posedge clock) begin
      if (cmd.set_resp) begin
         if (cmd.do_write && 32'(count_ff) < DEPTH) begin
            rsp_entry_count <= count_ff + COUNT_W'(1);
         end else if (cmd.do_clear && count_ff != '0) begin
            rsp_entry_count <= count_ff - COUNT_W'(1);
         end else begin
            rsp_entry_count <= count_ff;
         end
      end
   end

   always_comb begin
      sts.mod_done   = (32'(bit_ff) == MW);
      sts.slot_valid = vld_rd_ff;
      sts.slot_match = vld_rd_ff && rd_hash_ff == hash_ff && rd_key_ff == key_ff
                       && (HASH_BITS <= 32 || 1'b1);
      sts.wrap_home  = (idx_nx == home_ff);
      sts.limit_hit  = (32'(steps_ff) + 1 >= PROBE_LIMIT);
      sts.op         = op_ff;
   end
endmodule

// ----- sv/lpht_ctrl.sv -----
// controller state machine for the linear probe hash table
`include "linear_probe_hash_table_assert.svh"
module lpht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lpht_pkg::cmd_type cmd,
   input  lpht_pkg::sts_type sts
);
   import lpht_pkg::*;
   typedef enum logic [2:0] {S_IDLE, S_MOD, S_READ, S_EVAL, S_RESP} state_type;
   state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (sts.mod_done) state_in = S_READ;
            else cmd.mod_step = 1'b1;
         end
         S_READ: begin
            cmd.probe_rd = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            // hold while the previous response word still waits
            if (!(rsp_valid_ff && rsp_stall)) begin
               state_in = S_RESP;
               cmd.set_resp = 1'b1;
               if (sts.op == OP_ADD) begin
                  if (!sts.slot_valid) begin
                     cmd.do_write = 1'b1;
                     cmd.status = ST_ADDED;
                  end else if (sts.slot_match) begin
                     cmd.status = ST_DUP;
                  end else if (sts.limit_hit) begin
                     cmd.status = ST_NOSPACE;
                  end else begin
                     cmd.set_resp = 1'b0;
                     cmd.advance = 1'b1;
                     state_in = S_READ;
                  end
               end else if (sts.op == OP_DELETE || sts.op == OP_LOOKUP) begin
                  if (sts.slot_match) begin
                     cmd.status = ST_FOUND;
                     cmd.use_data = (sts.op == OP_LOOKUP);
                     cmd.do_clear = (sts.op == OP_DELETE);
                  end else if (sts.limit_hit || sts.wrap_home) begin
                     cmd.status = ST_NOTFOUND;
                  end else begin
                     cmd.set_resp = 1'b0;
                     cmd.advance = 1'b1;
                     state_in = S_READ;
                  end
               end else begin
                  cmd.status = ST_NOTFOUND;
               end
            end
         end
         S_RESP: begin
            // wait for the output register to be free
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `LPHT_ASSERT_IMP(a_no_accept_busy, state_ff != S_IDLE, req_stall)
   `LPHT_ASSERT_IMP(a_wr_clr_excl, 1'b1, !(cmd.do_write && cmd.do_clear))
   `LPHT_ASSERT_NEXT(a_load_to_mod, cmd.load, state_ff == S_MOD)
   `LPHT_ASSERT_NEXT(a_resp_hold, rsp_valid_ff && rsp_stall, rsp_valid_ff)
endmodule

// ----- sv/linear_probe_hash_table.sv -----
// top level of the linear probe hash table
// usage:
// - request word on req_*: operation (add, delete, lookup), key, hash code,
//   write data; accepted when req_valid is high and req_stall low
// - one response word per request on rsp_*: status, read data, entry count
// - csr_write_enable/csr_write_data set the slot count in use (1..DEPTH);
//   write only while idle
// - sequence: the hash code is reduced modulo the slot count (one restoring
//   step a cycle), then each slot probed is read and evaluated, then
//   rsp_valid is raised
// - one request in flight at a time; the next one can be taken in the
//   cycle rsp_valid rises; the modulo and the probe loop over the slot
//   memory port set the rate
// - reset empties the table (valid map cleared at once), count to zero,
//   slot count back to 256
// - rsp stall holds the response word; the next request is still taken and
//   probed, then waits before its result until the response register is free
module linear_probe_hash_table #(
   parameter int DEPTH       = lpht_pkg::DEPTH_DEF,
   parameter int PROBE_LIMIT = lpht_pkg::PROBE_LIMIT_DEF,
   parameter int KEY_BITS    = lpht_pkg::KEY_BITS_DEF,
   parameter int HASH_BITS   = lpht_pkg::HASH_BITS_DEF,
   parameter int DATA_BITS   = lpht_pkg::DATA_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_operation,
   input  logic [lpht_pkg::KEY_W-1:0]  req_key,
   input  logic [lpht_pkg::HASH_W-1:0] req_hash_code,
   input  logic [lpht_pkg::DATA_W-1:0] req_write_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lpht_pkg::STATUS_W-1:0] rsp_status,
   output logic [lpht_pkg::DATA_W-1:0] rsp_read_data,
   output logic [lpht_pkg::COUNT_W-1:0] rsp_entry_count,
   input  logic                        csr_write_enable,
   input  logic [lpht_pkg::LIMIT_W-1:0] csr_write_data
);
   import lpht_pkg::*;
   cmd_type cmd;
   sts_type sts;
   logic [LIMIT_W-1:0] limit_ff;

   // slot count register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   lpht_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .cmd, .sts
   );

   lpht_datapath #(
      .DEPTH(DEPTH), .PROBE_LIMIT(PROBE_LIMIT), .KEY_BITS(KEY_BITS),
      .HASH_BITS(HASH_BITS), .DATA_BITS(DATA_BITS)
   ) u_dp (
      .clock, .reset, .cmd, .sts, .req_operation, .req_key, .req_hash_code,
      .req_write_data, .limit(limit_ff), .rsp_status, .rsp_read_data,
      .rsp_entry_count
   );
endmodule
